// File: hw/rtl/incremental_rate_pid_3axis_unit_assert.svh
// assertion macros shared by the rate pid rtl
`ifndef INCREMENTAL_RATE_PID_3AXIS_UNIT_ASSERT_SVH
`define INCREMENTAL_RATE_PID_3AXIS_UNIT_ASSERT_SVH
`ifndef SYNTHESIS
`define RPID_ASSERT(label, prop) \
  label: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("rpid assertion failed");
`define RPID_ASSERT_RST(label, prop) \
  label: assert property (@(posedge clk) prop) \
    else $error("rpid assertion failed");
`else
`define RPID_ASSERT(label, prop)
`define RPID_ASSERT_RST(label, prop)
`endif
`endif

// File: hw/rtl/rpid_pkg.sv
// types, widths and constants of the rate pid
package rpid_pkg;

  localparam int FracBits = 16;
  localparam int UpW      = 18;
  localparam int RateW    = 32;
  localparam int GainW    = 21;
  localparam int FracW    = 17;
  localparam int AccW     = 32;
  localparam int TLimBits = 39;
  localparam int TW       = TLimBits + 1;
  localparam int MulAW    = 22;
  localparam int MulBW    = 41;
  localparam int ProdW    = MulAW + MulBW;
  localparam int N2W      = 36;
  localparam int DotW     = 51;
  localparam int MagW     = 50;
  localparam int MagHalf  = MagW / 2;
  localparam int NumW     = 67;
  localparam int SrcW     = 48;
  localparam int SumW     = 60;
  localparam int AccSumW  = 46;
  localparam int CfgIdxW  = 8;
  localparam int CfgDataW = 32;

  localparam logic [GainW-1:0] KpReset   = GainW'(1 << (FracBits - 1));
  localparam logic [GainW-1:0] KiReset   = GainW'(((1 << FracBits) + 5000) / 10000);
  localparam logic [GainW-1:0] KdReset   = GainW'(((1 << FracBits) + 5) / 10);
  localparam logic [FracW-1:0] FracReset = FracW'(((8 << FracBits) + 5) / 10);

  localparam logic [CfgIdxW-1:0] RegKp   = 8'd0;
  localparam logic [CfgIdxW-1:0] RegKi   = 8'd1;
  localparam logic [CfgIdxW-1:0] RegKd   = 8'd2;
  localparam logic [CfgIdxW-1:0] RegFrac = 8'd3;

  typedef struct packed {
    logic [2:0][UpW-1:0]   up;
    logic [2:0][RateW-1:0] act;
    logic [2:0][RateW-1:0] des;
    logic                  up_zero;
  } item_t;

  typedef struct packed {
    logic [GainW-1:0] kp;
    logic [GainW-1:0] ki;
    logic [GainW-1:0] kd;
    logic [FracW-1:0] frac;
  } cfg_t;

  typedef enum logic [2:0] {
    S_IDLE, S_DOT, S_NUM, S_DIV, S_REM, S_FIN
  } back_state_t;

endpackage

// File: hw/rtl/incremental_rate_pid_3axis_unit.sv
// top level of the three-axis incremental rate pid
// Usage:
// - input channel in_valid/in_stall carries one item: up vector, measured
//   rate and desired rate. It is taken when in_valid is high and in_stall low.
// - output channel out_valid/out_stall returns one result item per input:
//   the three saturated accumulators and the saturated flag.
// - configuration: cfg_valid/cfg_ready with cfg_index and cfg_data; index 0
//   proportional gain, 1 integral gain, 2 derivative gain, 3 yaw removal
//   fraction; other indexes are ignored. cfg_ready is always high.
// Flow: the back end runs each item through the single shared multiplier
// (28 operations, each with a multiply phase and an accumulate phase) and the
// bit-serial divider; a zero up vector skips the divider and the numerator
// products. A two-entry queue sits in front.
// Reset clears the error history, the accumulators and the queue, and loads
// the default gains. A stalled output holds its item; the back end then
// finishes the next item and waits, and the queue fills and raises in_stall.
module incremental_rate_pid_3axis_unit (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [rpid_pkg::UpW-1:0]      up_x,
  input  logic [rpid_pkg::UpW-1:0]      up_y,
  input  logic [rpid_pkg::UpW-1:0]      up_z,
  input  logic [rpid_pkg::RateW-1:0]    actual_rate_x,
  input  logic [rpid_pkg::RateW-1:0]    actual_rate_y,
  input  logic [rpid_pkg::RateW-1:0]    actual_rate_z,
  input  logic [rpid_pkg::RateW-1:0]    desired_rate_x,
  input  logic [rpid_pkg::RateW-1:0]    desired_rate_y,
  input  logic [rpid_pkg::RateW-1:0]    desired_rate_z,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [rpid_pkg::AccW-1:0]     accel_x,
  output logic [rpid_pkg::AccW-1:0]     accel_y,
  output logic [rpid_pkg::AccW-1:0]     accel_z,
  output logic                          saturated,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [rpid_pkg::CfgIdxW-1:0]  cfg_index,
  input  logic [rpid_pkg::CfgDataW-1:0] cfg_data
);

  rpid_pkg::cfg_t  cfg;
  rpid_pkg::item_t q_item;
  logic            q_valid;
  logic            q_pop;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.kp   <= rpid_pkg::KpReset;
      cfg.ki   <= rpid_pkg::KiReset;
      cfg.kd   <= rpid_pkg::KdReset;
      cfg.frac <= rpid_pkg::FracReset;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        rpid_pkg::RegKp:   cfg.kp   <= cfg_data[rpid_pkg::GainW-1:0];
        rpid_pkg::RegKi:   cfg.ki   <= cfg_data[rpid_pkg::GainW-1:0];
        rpid_pkg::RegKd:   cfg.kd   <= cfg_data[rpid_pkg::GainW-1:0];
        rpid_pkg::RegFrac: cfg.frac <= cfg_data[rpid_pkg::FracW-1:0];
        default: begin
        end
      endcase
    end
  end

  rpid_front u_front (
    .clk            (clk),
    .rst            (rst),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .up_x           (up_x),
    .up_y           (up_y),
    .up_z           (up_z),
    .actual_rate_x  (actual_rate_x),
    .actual_rate_y  (actual_rate_y),
    .actual_rate_z  (actual_rate_z),
    .desired_rate_x (desired_rate_x),
    .desired_rate_y (desired_rate_y),
    .desired_rate_z (desired_rate_z),
    .q_valid        (q_valid),
    .q_item         (q_item),
    .q_pop          (q_pop)
  );

  rpid_back u_back (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .q_valid   (q_valid),
    .q_item    (q_item),
    .q_pop     (q_pop),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .accel_x   (accel_x),
    .accel_y   (accel_y),
    .accel_z   (accel_z),
    .saturated (saturated)
  );

endmodule

// File: hw/rtl/rpid_front.sv
// input side: accepts items, flags a zero up vector, two-entry queue
`include "incremental_rate_pid_3axis_unit_assert.svh"
module rpid_front (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic [rpid_pkg::UpW-1:0]     up_x,
  input  logic [rpid_pkg::UpW-1:0]     up_y,
  input  logic [rpid_pkg::UpW-1:0]     up_z,
  input  logic [rpid_pkg::RateW-1:0]   actual_rate_x,
  input  logic [rpid_pkg::RateW-1:0]   actual_rate_y,
  input  logic [rpid_pkg::RateW-1:0]   actual_rate_z,
  input  logic [rpid_pkg::RateW-1:0]   desired_rate_x,
  input  logic [rpid_pkg::RateW-1:0]   desired_rate_y,
  input  logic [rpid_pkg::RateW-1:0]   desired_rate_z,
  output logic                         q_valid,
  output rpid_pkg::item_t              q_item,
  input  logic                         q_pop
);

  rpid_pkg::item_t mem [2];
  rpid_pkg::item_t item_in;
  logic            wr_ptr;
  logic            rd_ptr;
  logic [1:0]      count;
  logic            push;
  logic            pop;

  always_comb begin
    item_in.up      = {up_z, up_y, up_x};
    item_in.act     = {actual_rate_z, actual_rate_y, actual_rate_x};
    item_in.des     = {desired_rate_z, desired_rate_y, desired_rate_x};
    // zero up vector: the removal is skipped later
    item_in.up_zero = (up_x == '0) && (up_y == '0) && (up_z == '0);
  end

  assign in_stall = (count == 2'd2);
  assign push     = in_valid && !in_stall;
  assign q_valid  = (count != 2'd0);
  assign pop      = q_pop && q_valid;
  assign q_item   = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) wr_ptr <= !wr_ptr;
      if (pop) rd_ptr <= !rd_ptr;
      if (push && !pop) count <= count + 2'd1;
      else if (pop && !push) count <= count - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (push) mem[wr_ptr] <= item_in;
  end

  `RPID_ASSERT(a_count_range, count != 2'd3)
  `RPID_ASSERT(a_push_grows, push && !pop |=> count == $past(count) + 2'd1)
  `RPID_ASSERT(a_pop_nonempty, q_pop |-> q_valid)

endmodule

// File: hw/rtl/rpid_div.sv
// two-lane restoring divider, one quotient bit per cycle, shared divisor
module rpid_div (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       start,
  input  logic [rpid_pkg::NumW-1:0]  num_a,
  input  logic [rpid_pkg::NumW-1:0]  num_b,
  input  logic [rpid_pkg::N2W-1:0]   den,
  output logic                       done,
  output logic [rpid_pkg::NumW-1:0]  quo_a,
  output logic [rpid_pkg::NumW-1:0]  quo_b
);

  localparam int CntW = $clog2(rpid_pkg::NumW + 1);

  logic [rpid_pkg::NumW-1:0] na;
  logic [rpid_pkg::NumW-1:0] nb;
  logic [rpid_pkg::N2W-1:0]  ra;
  logic [rpid_pkg::N2W-1:0]  rb;
  logic [rpid_pkg::N2W-1:0]  dv;
  logic [rpid_pkg::N2W:0]    sha;
  logic [rpid_pkg::N2W:0]    shb;
  logic                      gea;
  logic                      geb;
  logic [CntW-1:0]           cnt;
  logic                      busy;

  always_comb begin
    sha = {ra, na[rpid_pkg::NumW-1]};
    shb = {rb, nb[rpid_pkg::NumW-1]};
    gea = sha >= {1'b0, dv};
    geb = shb >= {1'b0, dv};
  end

  assign quo_a = na;
  assign quo_b = nb;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= CntW'(rpid_pkg::NumW);
      end else if (busy) begin
        cnt <= cnt - CntW'(1);
        if (cnt == CntW'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // numerator registers shift out dividend bits and collect quotient bits
  always_ff @(posedge clk) begin
    if (start) begin
      na <= num_a;
      nb <= num_b;
      ra <= '0;
      rb <= '0;
      dv <= den;
    end else if (busy) begin
      na <= {na[rpid_pkg::NumW-2:0], gea};
      nb <= {nb[rpid_pkg::NumW-2:0], geb};
      ra <= gea ? rpid_pkg::N2W'(sha - {1'b0, dv}) : sha[rpid_pkg::N2W-1:0];
      rb <= geb ? rpid_pkg::N2W'(shb - {1'b0, dv}) : shb[rpid_pkg::N2W-1:0];
    end
  end

endmodule

// File: hw/rtl/rpid_back.sv
// back side: sequencer with shared multiplier, removal, pid update, output register
`include "incremental_rate_pid_3axis_unit_assert.svh"
module rpid_back (
  input  logic                          clk,
  input  logic                          rst,
  input  rpid_pkg::cfg_t                cfg,
  input  logic                          q_valid,
  input  rpid_pkg::item_t               q_item,
  output logic                          q_pop,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [rpid_pkg::AccW-1:0]     accel_x,
  output logic [rpid_pkg::AccW-1:0]     accel_y,
  output logic [rpid_pkg::AccW-1:0]     accel_z,
  output logic                          saturated
);

  localparam logic signed [rpid_pkg::AccW-1:0] AccMax = {1'b0, {(rpid_pkg::AccW-1){1'b1}}};
  localparam logic signed [rpid_pkg::AccW-1:0] AccMin = {1'b1, {(rpid_pkg::AccW-1){1'b0}}};

  rpid_pkg::back_state_t state, state_next;
  logic [1:0] axis, axis_next;
  logic [2:0] sub, sub_next;
  logic       ph, ph_next;
  logic       div_start;
  logic       div_done;
  logic       out_load;

  rpid_pkg::item_t cur;
  logic signed [rpid_pkg::MulAW-1:0] ma;
  logic signed [rpid_pkg::MulBW-1:0] mb;
  logic signed [rpid_pkg::ProdW-1:0] p;
  logic [rpid_pkg::N2W-1:0]          n2;
  logic signed [rpid_pkg::DotW-1:0]  dot_a;
  logic signed [rpid_pkg::DotW-1:0]  dot_d;
  logic [rpid_pkg::MagW-1:0]         mag_a;
  logic [rpid_pkg::MagW-1:0]         mag_d;
  logic [rpid_pkg::NumW-1:0]         num_a;
  logic [rpid_pkg::NumW-1:0]         num_d;
  logic [rpid_pkg::NumW-1:0]         quo_a;
  logic [rpid_pkg::NumW-1:0]         quo_d;
  logic [rpid_pkg::TW-1:0]           tmag_a;
  logic [rpid_pkg::TW-1:0]           tmag_d;
  logic signed [rpid_pkg::TW-1:0]    t_a;
  logic signed [rpid_pkg::TW-1:0]    t_d;
  logic signed [rpid_pkg::SrcW-1:0]  src;
  logic signed [rpid_pkg::SrcW-1:0]  dst_v;
  logic signed [rpid_pkg::SrcW:0]    ediff;
  logic signed [rpid_pkg::AccW-1:0]  e_sat;
  logic signed [rpid_pkg::AccW-1:0]  e_cur;
  logic signed [rpid_pkg::AccW:0]    de;
  logic signed [rpid_pkg::AccW+2:0]  dde;
  logic signed [rpid_pkg::SumW-1:0]  sum;
  logic signed [rpid_pkg::SumW-1:0]  sum_fin;
  logic signed [rpid_pkg::AccSumW-1:0] acc_v;
  logic signed [rpid_pkg::AccW-1:0]  acc_sat;
  logic                              acc_hit;
  logic                              hit;
  logic signed [rpid_pkg::AccW-1:0]  le [3];
  logic signed [rpid_pkg::AccW-1:0]  lb [3];
  logic signed [rpid_pkg::AccW-1:0]  acc [3];
  logic signed [rpid_pkg::MulAW-1:0] ui;
  logic signed [rpid_pkg::RateW-1:0] act_i;
  logic signed [rpid_pkg::RateW-1:0] des_i;

  rpid_div u_div (
    .clk   (clk),
    .rst   (rst),
    .start (div_start),
    .num_a (num_a),
    .num_b (num_d),
    .den   (n2),
    .done  (div_done),
    .quo_a (quo_a),
    .quo_b (quo_d)
  );

  // sequencer
  always_comb begin
    state_next = state;
    axis_next  = axis;
    sub_next   = sub;
    ph_next    = ph;
    q_pop      = 1'b0;
    div_start  = 1'b0;
    out_load   = 1'b0;
    unique case (state)
      rpid_pkg::S_IDLE: begin
        if (q_valid) begin
          q_pop      = 1'b1;
          state_next = rpid_pkg::S_DOT;
          axis_next  = 2'd0;
          sub_next   = 3'd0;
          ph_next    = 1'b0;
        end
      end
      rpid_pkg::S_DOT: begin
        ph_next = !ph;
        if (ph) begin
          if (sub == 3'd2) begin
            sub_next = 3'd0;
            if (axis == 2'd2) begin
              axis_next  = 2'd0;
              state_next = cur.up_zero ? rpid_pkg::S_REM : rpid_pkg::S_NUM;
            end else begin
              axis_next = axis + 2'd1;
            end
          end else begin
            sub_next = sub + 3'd1;
          end
        end
      end
      rpid_pkg::S_NUM: begin
        ph_next = !ph;
        if (ph) begin
          if (sub == 3'd3) begin
            sub_next   = 3'd0;
            state_next = rpid_pkg::S_DIV;
          end else begin
            sub_next = sub + 3'd1;
          end
        end
      end
      rpid_pkg::S_DIV: begin
        if (sub == 3'd0) begin
          div_start = 1'b1;
          sub_next  = 3'd1;
        end else if (div_done) begin
          sub_next   = 3'd0;
          axis_next  = 2'd0;
          ph_next    = 1'b0;
          state_next = rpid_pkg::S_REM;
        end
      end
      rpid_pkg::S_REM: begin
        ph_next = !ph;
        if (ph) begin
          if (sub == 3'd4) begin
            sub_next = 3'd0;
            if (axis == 2'd2) begin
              axis_next  = 2'd0;
              state_next = rpid_pkg::S_FIN;
            end else begin
              axis_next = axis + 2'd1;
            end
          end else begin
            sub_next = sub + 3'd1;
          end
        end
      end
      rpid_pkg::S_FIN: begin
        if (!out_valid || !out_stall) begin
          out_load   = 1'b1;
          state_next = rpid_pkg::S_IDLE;
        end
      end
      default: state_next = rpid_pkg::S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= rpid_pkg::S_IDLE;
      axis  <= 2'd0;
      sub   <= 3'd0;
      ph    <= 1'b0;
    end else begin
      state <= state_next;
      axis  <= axis_next;
      sub   <= sub_next;
      ph    <= ph_next;
    end
  end

  // operand and arithmetic helpers
  always_comb begin
    ui    = rpid_pkg::MulAW'($signed(cur.up[axis]));
    act_i = $signed(cur.act[axis]);
    des_i = $signed(cur.des[axis]);
    mag_a = rpid_pkg::MagW'(dot_a < 0 ? -dot_a : dot_a);
    mag_d = rpid_pkg::MagW'(dot_d < 0 ? -dot_d : dot_d);
    // quotient above the limit clamps
    tmag_a = (quo_a[rpid_pkg::NumW-1:rpid_pkg::TLimBits] != '0)
           ? {1'b0, {rpid_pkg::TLimBits{1'b1}}}
           : {1'b0, quo_a[rpid_pkg::TLimBits-1:0]};
    tmag_d = (quo_d[rpid_pkg::NumW-1:rpid_pkg::TLimBits] != '0)
           ? {1'b0, {rpid_pkg::TLimBits{1'b1}}}
           : {1'b0, quo_d[rpid_pkg::TLimBits-1:0]};
    dst_v = rpid_pkg::SrcW'(des_i) - rpid_pkg::SrcW'(p >>> rpid_pkg::FracBits);
    ediff = (rpid_pkg::SrcW+1)'(dst_v) - (rpid_pkg::SrcW+1)'(src);
    if (ediff > (rpid_pkg::SrcW+1)'(AccMax)) e_sat = AccMax;
    else if (ediff < (rpid_pkg::SrcW+1)'(AccMin)) e_sat = AccMin;
    else e_sat = rpid_pkg::AccW'(ediff);
    de  = (rpid_pkg::AccW+1)'(e_cur) - (rpid_pkg::AccW+1)'(le[axis]);
    dde = (rpid_pkg::AccW+3)'(e_cur) - ((rpid_pkg::AccW+3)'(le[axis]) <<< 1)
        + (rpid_pkg::AccW+3)'(lb[axis]);
    sum_fin = sum + rpid_pkg::SumW'(p);
    acc_v   = rpid_pkg::AccSumW'(acc[axis])
            + rpid_pkg::AccSumW'(sum_fin >>> rpid_pkg::FracBits);
    acc_hit = 1'b1;
    if (acc_v > rpid_pkg::AccSumW'(AccMax)) acc_sat = AccMax;
    else if (acc_v < rpid_pkg::AccSumW'(AccMin)) acc_sat = AccMin;
    else begin
      acc_sat = rpid_pkg::AccW'(acc_v);
      acc_hit = 1'b0;
    end
    ma = '0;
    mb = '0;
    case (state)
      rpid_pkg::S_DOT: begin
        ma = ui;
        case (sub)
          3'd0:    mb = rpid_pkg::MulBW'(ui);
          3'd1:    mb = rpid_pkg::MulBW'(act_i);
          default: mb = rpid_pkg::MulBW'(des_i);
        endcase
      end
      rpid_pkg::S_NUM: begin
        ma = rpid_pkg::MulAW'(cfg.frac);
        case (sub)
          3'd0:    mb = rpid_pkg::MulBW'(mag_a[rpid_pkg::MagHalf-1:0]);
          3'd1:    mb = rpid_pkg::MulBW'(mag_a[rpid_pkg::MagW-1:rpid_pkg::MagHalf]);
          3'd2:    mb = rpid_pkg::MulBW'(mag_d[rpid_pkg::MagHalf-1:0]);
          default: mb = rpid_pkg::MulBW'(mag_d[rpid_pkg::MagW-1:rpid_pkg::MagHalf]);
        endcase
      end
      rpid_pkg::S_REM: begin
        case (sub)
          3'd0: begin
            ma = ui;
            mb = rpid_pkg::MulBW'(t_a);
          end
          3'd1: begin
            ma = ui;
            mb = rpid_pkg::MulBW'(t_d);
          end
          3'd2: begin
            ma = rpid_pkg::MulAW'(cfg.kp);
            mb = rpid_pkg::MulBW'(de);
          end
          3'd3: begin
            ma = rpid_pkg::MulAW'(cfg.ki);
            mb = rpid_pkg::MulBW'(e_cur);
          end
          default: begin
            ma = rpid_pkg::MulAW'(cfg.kd);
            mb = rpid_pkg::MulBW'(dde);
          end
        endcase
      end
      default: begin
        ma = '0;
        mb = '0;
      end
    endcase
  end

  // loop state and output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      for (int i = 0; i < 3; i++) begin
        le[i]  <= '0;
        lb[i]  <= '0;
        acc[i] <= '0;
      end
    end else begin
      if (out_load) out_valid <= 1'b1;
      else if (!out_stall) out_valid <= 1'b0;
      if (state == rpid_pkg::S_REM && ph && sub == 3'd4) begin
        acc[axis] <= acc_sat;
        lb[axis]  <= le[axis];
        le[axis]  <= e_cur;
      end
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    if (q_pop) begin
      cur   <= q_item;
      n2    <= '0;
      dot_a <= '0;
      dot_d <= '0;
      num_a <= '0;
      num_d <= '0;
      t_a   <= '0;
      t_d   <= '0;
      hit   <= 1'b0;
    end
    if (!ph) p <= ma * mb;
    if (state == rpid_pkg::S_DIV && div_done) begin
      t_a <= dot_a < 0 ? -$signed(tmag_a) : $signed(tmag_a);
      t_d <= dot_d < 0 ? -$signed(tmag_d) : $signed(tmag_d);
    end
    if (ph) begin
      case (state)
        rpid_pkg::S_DOT: begin
          case (sub)
            3'd0:    n2 <= n2 + p[rpid_pkg::N2W-1:0];
            3'd1:    dot_a <= dot_a + rpid_pkg::DotW'(p);
            default: dot_d <= dot_d + rpid_pkg::DotW'(p);
          endcase
        end
        rpid_pkg::S_NUM: begin
          case (sub)
            3'd0: num_a <= num_a
                         + rpid_pkg::NumW'(p[rpid_pkg::MagHalf+rpid_pkg::FracW-1:0]);
            3'd1: num_a <= num_a
                         + (rpid_pkg::NumW'(p[rpid_pkg::MagHalf+rpid_pkg::FracW-1:0])
                            << rpid_pkg::MagHalf);
            3'd2: num_d <= num_d
                         + rpid_pkg::NumW'(p[rpid_pkg::MagHalf+rpid_pkg::FracW-1:0]);
            default: num_d <= num_d
                         + (rpid_pkg::NumW'(p[rpid_pkg::MagHalf+rpid_pkg::FracW-1:0])
                            << rpid_pkg::MagHalf);
          endcase
        end
        rpid_pkg::S_REM: begin
          case (sub)
            3'd0: src <= rpid_pkg::SrcW'(act_i) - rpid_pkg::SrcW'(p >>> rpid_pkg::FracBits);
            3'd1: e_cur <= e_sat;
            3'd2: sum <= rpid_pkg::SumW'(p);
            3'd3: sum <= sum_fin;
            default: hit <= hit | acc_hit;
          endcase
        end
        default: begin
        end
      endcase
    end
    if (out_load) begin
      accel_x   <= acc[0];
      accel_y   <= acc[1];
      accel_z   <= acc[2];
      saturated <= hit;
    end
  end

  `RPID_ASSERT(a_div_to_rem, (state == rpid_pkg::S_DIV) && div_done |=> state == rpid_pkg::S_REM)
  `RPID_ASSERT_RST(a_pop_idle, q_pop |-> state == rpid_pkg::S_IDLE)
  `RPID_ASSERT(a_out_from_fin, $rose(out_valid) |-> $past(state) == rpid_pkg::S_FIN)

endmodule

// File: dv/incremental_rate_pid_3axis_unit_test.sv
// self-checking testbench of the three-axis incremental rate pid
module incremental_rate_pid_3axis_unit_test;
  timeunit 1ns;
  timeprecision 1ps;
  import rpid_pkg::*;

  localparam longint RateMax = 64'sd2147483647;
  localparam longint RateMin = -64'sd2147483648;
  localparam longint TLimit  = (64'sd1 <<< TLimBits) - 1;
  localparam int     DrainCycles = 200;

  typedef struct {
    logic signed [UpW-1:0]   up  [3];
    logic signed [RateW-1:0] act [3];
    logic signed [RateW-1:0] des [3];
  } rate_item_t;

  typedef struct {
    logic [AccW-1:0] accel [3];
    logic            sat;
  } accel_result_t;

  logic clk = 0;
  logic rst = 1;
  logic in_valid = 0;
  logic in_stall;
  logic [UpW-1:0] up_x = '0, up_y = '0, up_z = '0;
  logic [RateW-1:0] actual_rate_x = '0, actual_rate_y = '0, actual_rate_z = '0;
  logic [RateW-1:0] desired_rate_x = '0, desired_rate_y = '0, desired_rate_z = '0;
  logic out_valid;
  logic out_stall = 0;
  logic [AccW-1:0] accel_x, accel_y, accel_z;
  logic saturated;
  logic cfg_valid = 0;
  logic cfg_ready;
  logic [CfgIdxW-1:0] cfg_index = '0;
  logic [CfgDataW-1:0] cfg_data = '0;

  incremental_rate_pid_3axis_unit uut (.*);

  // predictor copy of registers and per-axis history
  logic [GainW-1:0] kp_q = KpReset, ki_q = KiReset, kd_q = KdReset;
  logic [FracW-1:0] frac_q = FracReset;
  longint err_last [3] = '{0, 0, 0};
  longint err_prev [3] = '{0, 0, 0};
  longint accel_acc [3] = '{0, 0, 0};

  accel_result_t accel_expected [$];
  int mismatches = 0;
  bit no_idle = 0;
  int out_hold = 0;

  initial forever #1 clk = ~clk;

  initial begin
    #5ms;
    $display("tb: failure");
    $finish;
  end

  function automatic longint removal_factor(longint dot, longint unsigned n2);
    logic [127:0] num, q;
    longint unsigned mag;
    mag = (dot < 0) ? longint'(-dot) : longint'(dot);
    num = 128'(frac_q) * 128'(mag);
    q = num / 128'(n2);
    if (q > 128'(TLimit)) q = 128'(TLimit);
    return (dot < 0) ? -longint'(q[63:0]) : longint'(q[63:0]);
  endfunction

  function automatic accel_result_t predict_accel(rate_item_t it);
    accel_result_t r;
    longint u [3], a [3], d [3];
    longint dot_a, dot_d, t_a, t_d, src, dst, e, e1, e2, sum, acc;
    longint unsigned n2;
    dot_a = 0; dot_d = 0; t_a = 0; t_d = 0; n2 = 0;
    r.sat = 0;
    for (int i = 0; i < 3; i++) begin
      u[i] = it.up[i];
      a[i] = it.act[i];
      d[i] = it.des[i];
      n2 += longint'(u[i] * u[i]);
      dot_a += u[i] * a[i];
      dot_d += u[i] * d[i];
    end
    // zero up vector leaves both rates untouched
    if (n2 != 0) begin
      t_a = removal_factor(dot_a, n2);
      t_d = removal_factor(dot_d, n2);
    end
    for (int i = 0; i < 3; i++) begin
      src = a[i] - ((u[i] * t_a) >>> FracBits);
      dst = d[i] - ((u[i] * t_d) >>> FracBits);
      e = dst - src;
      if (e > RateMax) e = RateMax;
      if (e < RateMin) e = RateMin;
      e1 = err_last[i];
      e2 = err_prev[i];
      sum = longint'(kp_q) * (e - e1) + longint'(ki_q) * e
          + longint'(kd_q) * (e - 2 * e1 + e2);
      acc = accel_acc[i] + (sum >>> FracBits);
      if (acc > RateMax) begin acc = RateMax; r.sat = 1; end
      if (acc < RateMin) begin acc = RateMin; r.sat = 1; end
      accel_acc[i] = acc;
      err_prev[i] = e1;
      err_last[i] = e;
      r.accel[i] = acc[31:0];
    end
    return r;
  endfunction

  task automatic send_item(rate_item_t it);
    int gap;
    gap = no_idle ? 0 : $urandom_range(0, 3);
    if (gap > 0) begin
      in_valid <= 0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1;
    up_x <= it.up[0]; up_y <= it.up[1]; up_z <= it.up[2];
    actual_rate_x <= it.act[0]; actual_rate_y <= it.act[1]; actual_rate_z <= it.act[2];
    desired_rate_x <= it.des[0]; desired_rate_y <= it.des[1]; desired_rate_z <= it.des[2];
    do @(posedge clk); while (in_stall);
    accel_expected.push_back(predict_accel(it));
  endtask

  // wait for every result, then let the back end settle
  task automatic drain();
    in_valid <= 0;
    @(posedge clk);
    while (accel_expected.size() != 0) @(posedge clk);
    repeat (DrainCycles) @(posedge clk);
  endtask

  task automatic write_reg(logic [CfgIdxW-1:0] idx, logic [CfgDataW-1:0] data);
    cfg_valid <= 1;
    cfg_index <= idx;
    cfg_data <= data;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 0;
    case (idx)
      RegKp:   kp_q = data[GainW-1:0];
      RegKi:   ki_q = data[GainW-1:0];
      RegKd:   kd_q = data[GainW-1:0];
      RegFrac: frac_q = data[FracW-1:0];
      default: ;
    endcase
    @(posedge clk);
  endtask

  task automatic set_gains(logic [31:0] kp, logic [31:0] ki, logic [31:0] kd,
                           logic [31:0] frac);
    drain();
    write_reg(RegKp, kp);
    write_reg(RegKi, ki);
    write_reg(RegKd, kd);
    write_reg(RegFrac, frac);
  endtask

  function automatic logic [RateW-1:0] rand_rate();
    case ($urandom_range(0, 5))
      0: return $urandom;
      1: return RateW'(int'($urandom_range(0, 2 * 262144)) - 262144);
      2: return RateW'(int'($urandom_range(0, 2 * 16777216)) - 16777216);
      3: return $urandom_range(0, 1) ? 32'h7fffffff : 32'h80000000;
      default: return RateW'(int'($urandom_range(0, 2 * 65536)) - 65536);
    endcase
  endfunction

  function automatic logic [UpW-1:0] rand_up_comp();
    case ($urandom_range(0, 4))
      0: return UpW'(int'($urandom_range(0, 6)) - 3);
      1: return $urandom_range(0, 1) ? UpW'(65536) : UpW'(-65536);
      default: return UpW'(int'($urandom_range(0, 131072)) - 65536);
    endcase
  endfunction

  function automatic rate_item_t rand_item();
    rate_item_t it;
    bit zero_up;
    zero_up = ($urandom_range(0, 15) == 0);
    for (int i = 0; i < 3; i++) begin
      it.up[i] = zero_up ? '0 : rand_up_comp();
      it.act[i] = rand_rate();
      it.des[i] = rand_rate();
    end
    return it;
  endfunction

  function automatic rate_item_t make_item(int ux, int uy, int uz,
                                           logic [31:0] a, logic [31:0] d);
    rate_item_t it;
    it.up[0] = UpW'(ux); it.up[1] = UpW'(uy); it.up[2] = UpW'(uz);
    for (int i = 0; i < 3; i++) begin
      it.act[i] = a;
      it.des[i] = d;
    end
    return it;
  endfunction

  // result side: compare and pace the output stall
  always @(posedge clk) begin
    accel_result_t want;
    if (!rst) begin
      if (out_valid && !out_stall) begin
        if (accel_expected.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) $display("unexpected item %h %h %h %b",
                                         accel_x, accel_y, accel_z, saturated);
        end else begin
          want = accel_expected.pop_front();
          if (accel_x !== want.accel[0] || accel_y !== want.accel[1] ||
              accel_z !== want.accel[2] || saturated !== want.sat) begin
            mismatches++;
            if (mismatches <= 10)
              $display("mismatch exp %h %h %h %b got %h %h %h %b",
                       want.accel[0], want.accel[1], want.accel[2], want.sat,
                       accel_x, accel_y, accel_z, saturated);
          end
        end
        out_hold = no_idle ? 0 : $urandom_range(0, 3);
      end else if (out_hold > 0) begin
        out_hold--;
      end
      out_stall <= (out_hold > 0);
    end
  end

  task automatic test_directed();
    send_item(make_item(0, 0, 0, 32'h0001_0000, 32'h0002_0000));
    send_item(make_item(0, 0, 0, 32'h8000_0000, 32'h7fff_ffff));
    send_item(make_item(0, 0, 0, 32'h7fff_ffff, 32'h8000_0000));
    send_item(make_item(65536, 0, 0, 32'h0003_0000, 32'hfffd_0000));
    send_item(make_item(0, 0, 65536, 32'h0000_8000, 32'h0001_0000));
    send_item(make_item(-65536, 65536, -65536, 32'h7fff_ffff, 32'h8000_0000));
    // tiny up vector with big rates drives the removal factor to its limit
    send_item(make_item(1, 0, 0, 32'h7fff_ffff, 32'h8000_0000));
    send_item(make_item(-1, 1, 0, 32'h8000_0000, 32'h7fff_ffff));
    send_item(make_item(0, 0, 1, 32'h0000_0000, 32'h7fff_ffff));
    send_item(make_item(46341, 46341, 0, 32'h0010_0000, 32'hffef_0000));
    // large gains push the accumulators to both rails
    set_gains(32'h001f_ffff, 32'h001f_ffff, 32'h001f_ffff, 32'h0001_ffff);
    send_item(make_item(0, 0, 0, 32'h8000_0000, 32'h7fff_ffff));
    send_item(make_item(0, 0, 0, 32'h8000_0000, 32'h7fff_ffff));
    send_item(make_item(0, 0, 0, 32'h7fff_ffff, 32'h8000_0000));
    send_item(make_item(0, 0, 0, 32'h7fff_ffff, 32'h8000_0000));
    send_item(make_item(1, -1, 1, 32'h7fff_ffff, 32'h8000_0000));
    set_gains(0, 0, 0, 0);
    send_item(make_item(65536, 0, 0, 32'h1234_5678, 32'h8765_4321));
    send_item(make_item(0, -65536, 0, 32'hffff_ffff, 32'h0000_0001));
    set_gains(32'd1048576, 32'd1048576, 32'd1048576, 32'd65536);
    send_item(make_item(65536, 0, 0, 32'h0001_0000, 32'hffff_0000));
    send_item(make_item(0, 0, -65536, 32'h0000_0001, 32'hffff_ffff));
    send_item(make_item(3, -2, 1, 32'h0fff_0000, 32'hf001_0000));
  endtask

  task automatic test_config_sweep();
    logic [31:0] kp, ki, kd, fr;
    for (int s = 0; s < 8; s++) begin
      case (s)
        0: begin kp = KpReset; ki = KiReset; kd = KdReset; fr = FracReset; end
        1: begin kp = 0; ki = 0; kd = 0; fr = 0; end
        2: begin kp = 32'hffff_ffff; ki = 32'hffff_ffff; kd = 32'hffff_ffff;
                 fr = 32'hffff_ffff; end
        3: begin kp = 1048576; ki = 0; kd = 1048576; fr = 65536; end
        default: begin kp = $urandom_range(0, 200000); ki = $urandom_range(0, 2000);
                       kd = $urandom_range(0, 100000); fr = $urandom; end
      endcase
      set_gains(kp, ki, kd, fr);
      // indexes past the register list must be ignored
      write_reg(CfgIdxW'(4 + $urandom_range(0, 251)), $urandom);
      repeat (100) send_item(rand_item());
    end
  endtask

  task automatic test_random();
    set_gains(KpReset, KiReset, KdReset, FracReset);
    repeat (500) send_item(rand_item());
    // back-to-back stretch with the output never stalled
    no_idle = 1;
    repeat (300) send_item(rand_item());
    no_idle = 0;
    // sender holds off until the block has emptied
    drain();
    repeat (300) send_item(rand_item());
  endtask

  initial begin
    repeat (9) @(posedge clk);
    rst <= 0;
    @(posedge clk);
    test_directed();
    test_config_sweep();
    test_random();
    drain();
    if (mismatches == 0)
      $display("tb: success");
    else
      $display("tb: failure");
    $finish;
  end

endmodule
